/* rtl/core/lpcd_pkg.sv */
// ----------------------------------------------------------------------------
// lpcd_pkg
// Types and constants shared by the length-prefixed command deframer.
// ----------------------------------------------------------------------------
package lpcd_pkg;

  localparam int unsigned LenBytes  = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 2;
  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 56;
  localparam int unsigned TuserOutW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOX_BYTES   = 2'd0,
    CFG_FIELD_BYTES = 2'd1
  } cfg_reg_e;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  typedef struct packed {
    logic        status;
    logic        last;
    logic [15:0] byte_offset;
    logic        has_data;
    logic [7:0]  data_byte;
    logic [15:0] field_index;
    logic [15:0] box_index;
  } result_t;

endpackage

/* rtl/core/length_prefixed_command_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_command_deframer
// A result beat passes the input register and then the result register before it is valid.
// Throughput: one input byte per cycle, held only by output backpressure.
// The input register and the result register are the two stages.
// Reset clears the frame counters and indices and sets both index widths
// to one byte; no clearing pass is needed.
// ----------------------------------------------------------------------------
module length_prefixed_command_deframer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave side, tdata: rx_byte
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lpcd_pkg::TdataInW-1:0]       s_axis_tdata,
  // master side, tdata: box_index, field_index, data_byte, byte_offset
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lpcd_pkg::TdataOutW-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast,
  // tuser: has_data, status
  output logic [lpcd_pkg::TuserOutW-1:0]      m_axis_tuser,
  // register write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  lpcd_pkg::cfg_idx_t                  cfg_index_i,
  input  lpcd_pkg::cfg_data_t                 cfg_data_i
);
  import lpcd_pkg::*;

  logic [1:0]  box_bytes_q, field_bytes_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  result_t     out_q, res_d;
  logic        res_valid_d;

  logic [15:0] bytes_seen_q, bytes_seen_d;
  logic [15:0] frame_length_q, frame_length_d;
  logic [7:0]  length_high_q, length_high_d;
  logic [15:0] box_accum_q, box_accum_d;
  logic [15:0] field_accum_q, field_accum_d;

  logic        advance;
  logic [2:0]  box_end, hdr;
  logic [16:0] pos_p1;
  logic [15:0] full_len;
  logic        is_last;
  logic        cfg_ok;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign cfg_ok        = (cfg_data_i == 2'd1) || (cfg_data_i == 2'd2);

  // register writes, bad widths ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_bytes_q   <= 2'd1;
      field_bytes_q <= 2'd1;
    end else if (cfg_valid_i && cfg_ok) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BOX_BYTES:   box_bytes_q   <= cfg_data_i;
        CFG_FIELD_BYTES: field_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  assign box_end  = 3'(LenBytes) + {1'b0, box_bytes_q};
  assign hdr      = box_end + {1'b0, field_bytes_q};
  assign pos_p1   = {1'b0, bytes_seen_q} + 17'd1;
  assign full_len = {length_high_q, in_byte_q};
  assign is_last  = pos_p1 >= {1'b0, frame_length_q};

  // frame parse
  always_comb begin
    bytes_seen_d   = bytes_seen_q;
    frame_length_d = frame_length_q;
    length_high_d  = length_high_q;
    box_accum_d    = box_accum_q;
    field_accum_d  = field_accum_q;
    res_valid_d    = 1'b0;
    res_d          = '0;
    if (bytes_seen_q == 16'd0) begin
      length_high_d = in_byte_q;
      box_accum_d   = '0;
      field_accum_d = '0;
      bytes_seen_d  = 16'd1;
    end else if (bytes_seen_q == 16'd1) begin
      if (full_len < {13'd0, hdr}) begin
        bytes_seen_d   = '0;
        frame_length_d = '0;
        length_high_d  = '0;
        res_valid_d    = 1'b1;
        res_d.last     = 1'b1;
        res_d.status   = 1'b1;
      end else begin
        frame_length_d = full_len;
        bytes_seen_d   = 16'd2;
      end
    end else begin
      if (bytes_seen_q < {13'd0, box_end}) begin
        box_accum_d = {box_accum_q[7:0], in_byte_q};
      end else if (bytes_seen_q < {13'd0, hdr}) begin
        field_accum_d = {field_accum_q[7:0], in_byte_q};
      end
      if (is_last) begin
        bytes_seen_d   = '0;
        frame_length_d = '0;
        length_high_d  = '0;
      end else begin
        bytes_seen_d = pos_p1[15:0];
      end
      if (bytes_seen_q < {13'd0, hdr}) begin
        if (is_last) begin
          res_valid_d = 1'b1;
          res_d.last  = 1'b1;
          if (pos_p1 < {14'd0, hdr}) begin
            res_d.status = 1'b1;
          end else begin
            res_d.box_index   = box_accum_d;
            res_d.field_index = field_accum_d;
          end
        end
      end else begin
        res_valid_d       = 1'b1;
        res_d.box_index   = box_accum_d;
        res_d.field_index = field_accum_d;
        res_d.data_byte   = in_byte_q;
        res_d.has_data    = 1'b1;
        res_d.byte_offset = bytes_seen_q - {13'd0, hdr};
        res_d.last        = is_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q   <= '0;
      frame_length_q <= '0;
      length_high_q  <= '0;
      box_accum_q    <= '0;
      field_accum_q  <= '0;
    end else if (advance) begin
      bytes_seen_q   <= bytes_seen_d;
      frame_length_q <= frame_length_d;
      length_high_q  <= length_high_d;
      box_accum_q    <= box_accum_d;
      field_accum_q  <= field_accum_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid_d;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid_d) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.byte_offset, out_q.data_byte, out_q.field_index,
                          out_q.box_index};
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = {out_q.status, out_q.has_data};

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status |-> out_q.last && !out_q.has_data)
    else $error("error beat not marked last or carries data");

  a_widths_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (box_bytes_q == 2'd1 || box_bytes_q == 2'd2) &&
    (field_bytes_q == 2'd1 || field_bytes_q == 2'd2))
    else $error("index width register out of range");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("stalled input byte lost");

  a_len_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid_d && res_d.last |=> bytes_seen_q == 16'd0)
    else $error("frame counter not cleared after last beat");
`endif

endmodule
